### hdl/sghl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spatial grid hit lookup package
// Shared constants, request and result beat types, and the cell entry layout.
// ----------------------------------------------------------------------------
package sghl_pkg;

    localparam int CELL_SIZE = 32;
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;

    localparam int COORD_W = 11;
    localparam int RAD_W   = 8;
    localparam int ID_W    = 8;
    localparam int REQ_W   = 2;

    // Signed scan coordinate: query point minus search radius, stepped past
    // the far edge by up to one cell.
    localparam int SCAN_W     = 13;
    // Cell index reached while scanning (before the grid bound is applied).
    localparam int CELL_IDX_W = 12;

    localparam logic [REQ_W-1:0] REQ_PLACE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [RAD_W-1:0]   target_radius;
        logic [RAD_W-1:0]   search_radius;
        logic               is_active;
        logic [ID_W-1:0]    target_id;
    } t_req;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] hit_id;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RAD_W-1:0]   rad;
    } t_cell;

    localparam int CELL_W = $bits(t_cell);

endpackage
`default_nettype wire

### hdl/sghl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sghl_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hdl/spatial_grid_hit_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spatial grid hit lookup
// Grid of cells in one RAM, one target per cell; place, query and clear.
// ----------------------------------------------------------------------------
// Place: strobe after states S_DIV and S_PLACE; an unused request code strobes from S_IDLE.
// Query: S_DIV, then S_SCAN reads the cell RAM, one cell a cycle, into p1 and then p2; the
//   strobe follows the first hit or the last cell; at most (2*search_radius/CELL_SIZE + 1)^2
//   cells are read. Clear: one RAM write per cell, then the strobe. One item at a time.
// Reset runs the same clearing pass with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module spatial_grid_hit_lookup #(
    parameter int CELL_SIZE = sghl_pkg::CELL_SIZE,
    parameter int GRID_COLS = sghl_pkg::GRID_COLS,
    parameter int GRID_ROWS = sghl_pkg::GRID_ROWS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire sghl_pkg::t_req   i_req,
    output logic                  o_done,
    output sghl_pkg::t_result     o_result
);

    localparam int DEPTH   = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COORD_W = sghl_pkg::COORD_W;
    localparam int SCAN_W  = sghl_pkg::SCAN_W;
    localparam int IDX_W   = sghl_pkg::CELL_IDX_W;
    localparam int ID_W    = sghl_pkg::ID_W;
    localparam int RAD_W   = sghl_pkg::RAD_W;
    localparam int CELL_W  = sghl_pkg::CELL_W;

    // Division by the cell size as a multiply by a rounded-up reciprocal,
    // exact for every dividend below 2**COORD_W.
    localparam int RECIP_SHIFT = COORD_W + $clog2(CELL_SIZE);
    localparam int RECIP_W     = COORD_W + 2;
    localparam int PROD_W      = COORD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + CELL_SIZE - 1) / CELL_SIZE);

    localparam logic signed [SCAN_W-1:0] CELL_S   = SCAN_W'(CELL_SIZE);
    localparam logic [ADDR_W-1:0]        LAST_ADR = ADDR_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0]         COLS_I   = IDX_W'(GRID_COLS);
    localparam logic [IDX_W-1:0]         ROWS_I   = IDX_W'(GRID_ROWS);
    localparam int SQ_W = 2 * COORD_W;
    localparam int R2_W = 2 * RAD_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_PLACE = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    // Control registers.
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_clr_reply, n_clr_reply;
    logic              r_p1_vld, n_p1_vld;
    logic              r_p2_vld, n_p2_vld;
    logic              r_done, n_done;

    // Payload registers.
    sghl_pkg::t_req           r_req, n_req;
    logic [COORD_W-1:0]       r_qx, n_qx;
    logic [COORD_W-1:0]       r_qy, n_qy;
    logic signed [SCAN_W-1:0] r_x, n_x;
    logic signed [SCAN_W-1:0] r_y, n_y;
    logic signed [SCAN_W-1:0] r_y0, n_y0;
    logic signed [SCAN_W-1:0] r_x_end, n_x_end;
    logic signed [SCAN_W-1:0] r_y_end, n_y_end;
    logic [IDX_W-1:0]         r_cx, n_cx;
    logic [IDX_W-1:0]         r_cy, n_cy;
    logic [IDX_W-1:0]         r_cy0, n_cy0;
    logic                     r_p1_in, n_p1_in;
    logic                     r_p1_last, n_p1_last;
    logic                     r_p2_ok, n_p2_ok;
    logic                     r_p2_last, n_p2_last;
    logic [ID_W-1:0]          r_p2_id, n_p2_id;
    logic [SQ_W-1:0]          r_p2_dx2, n_p2_dx2;
    logic [SQ_W-1:0]          r_p2_dy2, n_p2_dy2;
    logic [R2_W-1:0]          r_p2_r2, n_p2_r2;
    logic                     r_hit, n_hit;
    logic [ID_W-1:0]          r_hit_id, n_hit_id;

    // RAM ports.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [CELL_W-1:0] w_wdata;
    logic [CELL_W-1:0] w_rdata;

    sghl_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Scan window corners and the cell division.
    logic signed [SCAN_W-1:0] w_x0, w_y0, w_xe, w_ye;
    logic [COORD_W-1:0]       w_div_x, w_div_y;
    logic [PROD_W-1:0]        w_prod_x, w_prod_y;
    logic [COORD_W-1:0]       w_quo_x, w_quo_y;

    always_comb begin
        w_x0 = $signed({2'b00, r_req.pos_x}) - $signed({5'b00000, r_req.search_radius});
        w_y0 = $signed({2'b00, r_req.pos_y}) - $signed({5'b00000, r_req.search_radius});
        w_xe = $signed({2'b00, r_req.pos_x}) + $signed({5'b00000, r_req.search_radius});
        w_ye = $signed({2'b00, r_req.pos_y}) + $signed({5'b00000, r_req.search_radius});
        // A negative scan start reaches cell 0 first, so its start column or row is 0.
        if (r_req.req_type == sghl_pkg::REQ_PLACE) begin
            w_div_x = r_req.pos_x;
            w_div_y = r_req.pos_y;
        end else begin
            w_div_x = w_x0[SCAN_W-1] ? '0 : w_x0[COORD_W-1:0];
            w_div_y = w_y0[SCAN_W-1] ? '0 : w_y0[COORD_W-1:0];
        end
        w_prod_x = PROD_W'(w_div_x) * PROD_W'(RECIP);
        w_prod_y = PROD_W'(w_div_y) * PROD_W'(RECIP);
        w_quo_x  = COORD_W'(w_prod_x >> RECIP_SHIFT);
        w_quo_y  = COORD_W'(w_prod_y >> RECIP_SHIFT);
    end

    // Current scan cell: negative coordinates above -CELL_SIZE truncate to 0.
    logic             w_x_in, w_y_in;
    logic [IDX_W-1:0] w_col, w_row;
    logic             w_y_more, w_x_more;
    logic signed [SCAN_W-1:0] w_y_step, w_x_step;

    always_comb begin
        w_x_in   = r_x[SCAN_W-1] ? (r_x > -CELL_S) : (r_cx < COLS_I);
        w_y_in   = r_y[SCAN_W-1] ? (r_y > -CELL_S) : (r_cy < ROWS_I);
        w_col    = r_x[SCAN_W-1] ? '0 : r_cx;
        w_row    = r_y[SCAN_W-1] ? '0 : r_cy;
        w_x_step = r_x + CELL_S;
        w_y_step = r_y + CELL_S;
        w_x_more = (w_x_step <= r_x_end);
        w_y_more = (w_y_step <= r_y_end);
    end

    // Second pipeline stage inputs: the cell read and squared distances; then the hit test.
    sghl_pkg::t_cell           w_cell;
    logic signed [COORD_W:0]   w_dx, w_dy;
    logic signed [2*COORD_W+1:0] w_dx2, w_dy2;
    logic [SQ_W:0]             w_d2;
    logic                      w_hit_now;

    always_comb begin
        w_cell    = sghl_pkg::t_cell'(w_rdata);
        w_dx      = $signed({1'b0, r_req.pos_x}) - $signed({1'b0, w_cell.x});
        w_dy      = $signed({1'b0, r_req.pos_y}) - $signed({1'b0, w_cell.y});
        w_dx2     = w_dx * w_dx;
        w_dy2     = w_dy * w_dy;
        w_d2      = {1'b0, r_p2_dx2} + {1'b0, r_p2_dy2};
        w_hit_now = r_p2_vld && r_p2_ok && (w_d2 <= (SQ_W + 1)'(r_p2_r2));
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_p1_vld    = 1'b0;
        n_done      = 1'b0;
        n_req       = r_req;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_x         = r_x;
        n_y         = r_y;
        n_y0        = r_y0;
        n_x_end     = r_x_end;
        n_y_end     = r_y_end;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cy0       = r_cy0;
        n_p1_in     = r_p1_in;
        n_p1_last   = r_p1_last;
        n_hit       = r_hit;
        n_hit_id    = r_hit_id;
        w_we        = 1'b0;
        w_waddr     = r_clr_addr;
        w_wdata     = '0;
        w_raddr     = ADDR_W'(32'(w_col) * 32'(GRID_ROWS) + 32'(w_row));

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADR) begin
                    n_state     = S_IDLE;
                    n_clr_reply = 1'b0;
                    if (r_clr_reply) begin
                        n_done   = 1'b1;
                        n_hit    = 1'b0;
                        n_hit_id = '0;
                    end
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    unique case (i_req.req_type)
                        sghl_pkg::REQ_PLACE, sghl_pkg::REQ_QUERY: begin
                            n_state = S_DIV;
                        end
                        sghl_pkg::REQ_CLEAR: begin
                            n_state     = S_CLEAR;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_hit    = 1'b0;
                            n_hit_id = '0;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_qx    = w_quo_x;
                n_qy    = w_quo_y;
                n_x     = w_x0;
                n_y     = w_y0;
                n_y0    = w_y0;
                n_x_end = w_xe;
                n_y_end = w_ye;
                n_cx    = {1'b0, w_quo_x};
                n_cy    = {1'b0, w_quo_y};
                n_cy0   = {1'b0, w_quo_y};
                n_state = (r_req.req_type == sghl_pkg::REQ_QUERY) ? S_SCAN : S_PLACE;
            end
            S_PLACE: begin
                w_waddr = ADDR_W'(32'(r_qx) * 32'(GRID_ROWS) + 32'(r_qy));
                w_we    = ({1'b0, r_qx} < COLS_I) && ({1'b0, r_qy} < ROWS_I);
                if (r_req.is_active) begin
                    w_wdata = {1'b1, r_req.target_id, r_req.pos_x, r_req.pos_y,
                               r_req.target_radius};
                end
                n_done   = 1'b1;
                n_hit    = 1'b0;
                n_hit_id = '0;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                n_p1_vld  = 1'b1;
                n_p1_in   = w_x_in && w_y_in;
                n_p1_last = !w_y_more && !w_x_more;
                if (w_y_more) begin
                    n_y  = w_y_step;
                    n_cy = r_y[SCAN_W-1] ? '0 : r_cy + 1'b1;
                end else begin
                    n_y  = r_y0;
                    n_cy = r_cy0;
                    n_x  = w_x_step;
                    n_cx = r_x[SCAN_W-1] ? '0 : r_cx + 1'b1;
                    if (!w_x_more) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The pipeline is in order, so the first hit seen is the first in scan order.
        n_p2_vld = r_p1_vld;
        if (r_p2_vld && (w_hit_now || r_p2_last)) begin
            n_done   = 1'b1;
            n_hit    = w_hit_now;
            n_hit_id = w_hit_now ? r_p2_id : '0;
            n_state  = S_IDLE;
            n_p1_vld = 1'b0;
            n_p2_vld = 1'b0;
        end
    end

    always_comb begin
        n_p2_ok   = r_p1_in && w_cell.valid;
        n_p2_last = r_p1_last;
        n_p2_id   = w_cell.id;
        n_p2_dx2  = w_dx2[SQ_W-1:0];
        n_p2_dy2  = w_dy2[SQ_W-1:0];
        n_p2_r2   = R2_W'(w_cell.rad) * R2_W'(w_cell.rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_p1_vld    <= n_p1_vld;
            r_p2_vld    <= n_p2_vld;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_x       <= n_x;
        r_y       <= n_y;
        r_y0      <= n_y0;
        r_x_end   <= n_x_end;
        r_y_end   <= n_y_end;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_cy0     <= n_cy0;
        r_p1_in   <= n_p1_in;
        r_p1_last <= n_p1_last;
        r_p2_ok   <= n_p2_ok;
        r_p2_last <= n_p2_last;
        r_p2_id   <= n_p2_id;
        r_p2_dx2  <= n_p2_dx2;
        r_p2_dy2  <= n_p2_dy2;
        r_p2_r2   <= n_p2_r2;
        r_hit     <= n_hit;
        r_hit_id  <= n_hit_id;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_result.hit    = r_hit;
    assign o_result.hit_id = r_hit_id;

    // A write never lands while query reads are in flight.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !(r_p1_vld || r_p2_vld))
        else $error("cell write during a query scan");

    // A result beat is only shown once the block is ready again.
    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_miss_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.hit) |-> (o_result.hit_id == '0))
        else $error("miss result with nonzero id");

    // An accepted beat either starts work or answers at once.
    a_accept_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted beat produced neither work nor result");

    a_stage2_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> $past(r_p1_vld))
        else $error("second stage valid without a read behind it");

endmodule
`default_nettype wire
